@@ hdl/rrm_pkg.sv @@
// Shared types and codes for the residency manager.
// Holds request, state, phase and loader command codes; no dependencies.
`timescale 1ns / 1ps

package rrm_pkg;

    // Request codes
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_GET     = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    // Residency states
    localparam logic [1:0] ST_UNLOADED  = 2'd0;
    localparam logic [1:0] ST_LOADING   = 2'd1;
    localparam logic [1:0] ST_LOADED    = 2'd2;
    localparam logic [1:0] ST_UNLOADING = 2'd3;

    // Load phases
    localparam logic [2:0] PH_IDLE        = 3'd0;
    localparam logic [2:0] PH_READ        = 3'd1;
    localparam logic [2:0] PH_WAIT_READ   = 3'd2;
    localparam logic [2:0] PH_DECODE      = 3'd3;
    localparam logic [2:0] PH_WAIT_DECODE = 3'd4;
    localparam logic [2:0] PH_END         = 3'd5;

    // Loader commands
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_SET_FILE = 3'd1;
    localparam logic [2:0] CMD_READ     = 3'd2;
    localparam logic [2:0] CMD_DECODE   = 3'd3;
    localparam logic [2:0] CMD_COPY     = 3'd4;
    localparam logic [2:0] CMD_FREE     = 3'd5;

    localparam int ID_WIDTH = 6;

    // Side results of one entry update
    typedef struct packed {
        logic [2:0] cmd;
        logic       advance;
    } upd_flags_t;

endpackage

@@ hdl/rrm_entry_mem.sv @@
// Entry table storage: one write port, one registered read port.
// Runs a zeroing pass over all entries after reset. Uses rrm_pkg.
`timescale 1ns / 1ps

module rrm_entry_mem
    import rrm_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 13
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    output logic          clearing
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_idx_reg == AW'(DEPTH - 1))
                clr_busy_reg <= 1'b0;
            else
                clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_idx_reg] <= '0;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_busy_reg;

endmodule

@@ hdl/rrm_entry_update.sv @@
// Next-state logic for one entry: get/release counting and tick sequencing.
// Purely combinational. Uses rrm_pkg.
`timescale 1ns / 1ps

module rrm_entry_update
    import rrm_pkg::*;
#(
    parameter int CW = 8
)
(
    input  logic [1:0]    req_type,
    input  logic          loader_done,
    input  logic [1:0]    res_cur,
    input  logic [2:0]    phase_cur,
    input  logic [CW-1:0] count_cur,
    output logic [1:0]    res_new,
    output logic [2:0]    phase_new,
    output logic [CW-1:0] count_new,
    output upd_flags_t    flags
);

    localparam logic [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};

    logic positive;

    assign positive = !count_cur[CW-1] && (count_cur != '0);

    always_comb
    begin
        res_new       = res_cur;
        phase_new     = phase_cur;
        count_new     = count_cur;
        flags.cmd     = CMD_NONE;
        flags.advance = 1'b0;
        unique case (req_type)
            REQ_GET:
            begin
                if (count_cur != CNT_MAX)
                    count_new = count_cur + 1'b1;
            end
            REQ_RELEASE:
            begin
                if (count_cur != CNT_MIN)
                    count_new = count_cur - 1'b1;
            end
            REQ_TICK:
            begin
                unique case (res_cur)
                    ST_UNLOADED:
                    begin
                        if (positive)
                        begin
                            res_new   = ST_LOADING;
                            phase_new = PH_IDLE;
                        end
                        else
                            flags.advance = 1'b1;
                    end
                    ST_LOADING:
                    begin
                        unique case (phase_cur)
                            PH_IDLE:
                            begin
                                flags.cmd = CMD_SET_FILE;
                                phase_new = PH_READ;
                            end
                            PH_READ:
                            begin
                                flags.cmd = CMD_READ;
                                phase_new = PH_WAIT_READ;
                            end
                            PH_WAIT_READ:
                            begin
                                if (loader_done)
                                    phase_new = PH_DECODE;
                            end
                            PH_DECODE:
                            begin
                                flags.cmd = CMD_DECODE;
                                phase_new = PH_WAIT_DECODE;
                            end
                            PH_WAIT_DECODE:
                            begin
                                if (loader_done)
                                    phase_new = PH_END;
                            end
                            PH_END:
                            begin
                                if (positive)
                                begin
                                    flags.cmd = CMD_COPY;
                                    res_new   = ST_LOADED;
                                end
                                else
                                    res_new = ST_UNLOADED;
                                phase_new = PH_IDLE;
                            end
                            default:
                                phase_new = PH_IDLE;
                        endcase
                    end
                    ST_LOADED:
                    begin
                        if (!positive)
                            res_new = ST_UNLOADING;
                        else
                            flags.advance = 1'b1;
                    end
                    ST_UNLOADING:
                    begin
                        if (positive)
                            res_new = ST_LOADED;
                        else
                        begin
                            flags.cmd = CMD_FREE;
                            res_new   = ST_UNLOADED;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

endmodule

@@ hdl/refcounted_residency_manager.sv @@
// Top level of the reference-counted residency manager.
// Instantiates rrm_entry_mem and rrm_entry_update; uses rrm_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request item: a tick that
//   processes the entry under the scan pointer, or a get/release on res_id.
//   Output channel (out_valid/out_ready) returns exactly one result item per
//   request: loader command, entry addressed, its state after the step and
//   the scan pointer after the step.
//   The accepting edge registers the entry table read; the update then runs
//   on the read word, and the edge on which the update stage advances loads
//   the result register, which raises out_valid. Throughput: one item per
//   cycle, back to back, also on the same entry (the update is forwarded
//   around the memory), while the result register drains and no clear runs.
//   Reset: after rst_n releases, the table is zeroed one entry per cycle;
//   in_ready stays low while this pass runs.
//   Stall: when out_ready is low the result register holds; one more item
//   can sit in the update stage, after which in_ready drops until the
//   receiver takes the waiting result.

module refcounted_residency_manager
    import rrm_pkg::*;
#(
    parameter int NUM_ENTRIES = 64,
    parameter int COUNT_WIDTH = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic [ID_WIDTH-1:0] res_id,
    input  logic                loader_done,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          loader_cmd,
    output logic [ID_WIDTH-1:0] cmd_entry,
    output logic [1:0]          entry_state,
    output logic                entry_loaded,
    output logic [ID_WIDTH-1:0] scan_position
);

    localparam int AW  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int IDW = (AW > ID_WIDTH) ? AW : ID_WIDTH;
    localparam int DW  = 2 + 3 + COUNT_WIDTH;

    // Handshake and table control
    logic          accept;
    logic          adv;
    logic          clearing;
    logic [AW-1:0] rd_addr;
    logic          rd_entry_ok;
    logic [DW-1:0] rd_data;
    logic [DW-1:0] wr_data;
    logic          wr_en;

    // Update stage
    logic                s1_valid_reg;
    logic [1:0]          s1_req_reg;
    logic [ID_WIDTH-1:0] s1_id_reg;
    logic                s1_done_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic                s1_ok_reg;
    logic                fwd_hit_reg;
    logic [DW-1:0]       fwd_data_reg;

    logic [AW-1:0] scan_ptr_reg;
    logic [AW-1:0] scan_ptr_next;

    logic [DW-1:0]          cur_word;
    logic [1:0]             res_new;
    logic [2:0]             phase_new;
    logic [COUNT_WIDTH-1:0] count_new;
    upd_flags_t             flags;
    logic [1:0]             state_after;

    logic [IDW-1:0] id_wide;
    logic [IDW-1:0] ptr_wide;
    logic [IDW-1:0] ptr_next_wide;

    // Output register
    logic                out_valid_reg;
    logic [2:0]          loader_cmd_reg;
    logic [ID_WIDTH-1:0] cmd_entry_reg;
    logic [1:0]          entry_state_reg;
    logic [ID_WIDTH-1:0] scan_position_reg;

    // Advance the update stage whenever the result register is free or drains
    assign adv      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clearing && (!s1_valid_reg || adv);
    assign accept   = in_valid && in_ready;

    // Pointer the next tick sees: after the step now in the update stage
    always_comb
    begin
        scan_ptr_next = scan_ptr_reg;
        if (adv && s1_ok_reg && flags.advance)
        begin
            if (scan_ptr_reg == AW'(NUM_ENTRIES - 1))
                scan_ptr_next = '0;
            else
                scan_ptr_next = scan_ptr_reg + 1'b1;
        end
    end

    assign id_wide = IDW'(res_id);

    // Table address of the incoming item; get/release beyond the table are dropped
    always_comb
    begin
        if (req_type == REQ_TICK)
        begin
            rd_addr     = scan_ptr_next;
            rd_entry_ok = 1'b1;
        end
        else
        begin
            rd_addr     = id_wide[AW-1:0];
            rd_entry_ok = (32'(res_id) < NUM_ENTRIES);
        end
    end

    assign wr_en   = adv && s1_ok_reg;
    assign wr_data = {res_new, phase_new, count_new};

    rrm_entry_mem #(
        .DEPTH (NUM_ENTRIES),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (s1_addr_reg),
        .wr_data  (wr_data),
        .clearing (clearing)
    );

    // Update stage registers; capture a same-edge write to the same entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg   <= req_type;
            s1_id_reg    <= res_id;
            s1_done_reg  <= loader_done;
            s1_addr_reg  <= rd_addr;
            s1_ok_reg    <= rd_entry_ok;
            fwd_hit_reg  <= wr_en && (s1_addr_reg == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_ptr_reg <= '0;
        else
            scan_ptr_reg <= scan_ptr_next;
    end

    assign cur_word = fwd_hit_reg ? fwd_data_reg : rd_data;

    rrm_entry_update #(
        .CW (COUNT_WIDTH)
    ) u_update (
        .req_type    (s1_req_reg),
        .loader_done (s1_done_reg),
        .res_cur     (cur_word[DW-1 -: 2]),
        .phase_cur   (cur_word[COUNT_WIDTH +: 3]),
        .count_cur   (cur_word[COUNT_WIDTH-1:0]),
        .res_new     (res_new),
        .phase_new   (phase_new),
        .count_new   (count_new),
        .flags       (flags)
    );

    assign state_after   = s1_ok_reg ? res_new : ST_UNLOADED;
    assign ptr_wide      = IDW'(scan_ptr_reg);
    assign ptr_next_wide = IDW'(scan_ptr_next);

    // Result register: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            loader_cmd_reg    <= s1_ok_reg ? flags.cmd : CMD_NONE;
            cmd_entry_reg     <= (s1_req_reg == REQ_TICK) ? ptr_wide[ID_WIDTH-1:0]
                                                          : s1_id_reg;
            entry_state_reg   <= state_after;
            scan_position_reg <= ptr_next_wide[ID_WIDTH-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign loader_cmd    = loader_cmd_reg;
    assign cmd_entry     = cmd_entry_reg;
    assign entry_state   = entry_state_reg;
    assign entry_loaded  = (entry_state_reg == ST_LOADED);
    assign scan_position = scan_position_reg;

    // No item enters while the table is being zeroed
    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ready)
        else $error("input accepted during table clear");

    // A copy always leaves the entry loaded
    a_copy_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && loader_cmd == CMD_COPY) |-> (entry_state == ST_LOADED))
        else $error("copy command without loaded state");

    // A free always leaves the entry unloaded
    a_free_unloaded: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && loader_cmd == CMD_FREE) |-> (entry_state == ST_UNLOADED))
        else $error("free command without unloaded state");

    // The scan pointer holds unless a step advances it
    a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(adv && s1_ok_reg && flags.advance) |=> $stable(scan_ptr_reg))
        else $error("scan pointer moved without an advance");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for refcounted_residency_manager.
// Depends on rrm_pkg and the top level under hdl/; predicts every result item
// from its own copy of the entry table and checks it at the output channel.
`timescale 1ns / 1ps

module testbench;
    import rrm_pkg::*;

    localparam int NUM_ENTRIES    = 64;
    localparam int COUNT_WIDTH    = 8;
    localparam int COUNT_MAX      = (1 << (COUNT_WIDTH - 1)) - 1;
    localparam int COUNT_MIN      = -COUNT_MAX - 1;
    // Request code that the block must treat as a no-op
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // Cycles without any accepted item before the run is declared hung;
    // covers the table clear after reset plus the longest stalls.
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles to watch for stray output items once nothing is pending
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int QUIET_TAIL     = 300;
    localparam int MAX_PRINTS     = 50;

    typedef struct packed {
        logic [2:0]          cmd;
        logic [ID_WIDTH-1:0] entry;
        logic [1:0]          state;
        logic                loaded;
        logic [ID_WIDTH-1:0] scan;
    } residency_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          req_type = REQ_TICK;
    logic [ID_WIDTH-1:0] res_id = '0;
    logic                loader_done = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b1;
    logic [2:0]          loader_cmd;
    logic [ID_WIDTH-1:0] cmd_entry;
    logic [1:0]          entry_state;
    logic                entry_loaded;
    logic [ID_WIDTH-1:0] scan_position;

    // Predicted entry table: residency, load phase, signed reference count
    logic [1:0]  tbl_state [NUM_ENTRIES];
    logic [2:0]  tbl_phase [NUM_ENTRIES];
    int          tbl_refs  [NUM_ENTRIES];
    int unsigned tbl_scan;

    residency_result_t pending_results [$];
    int  mismatches  = 0;
    int  idle_cycles = 0;
    int  sink_hold   = 0;
    bit  idling_on   = 1'b1;

    refcounted_residency_manager #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .res_id        (res_id),
        .loader_done   (loader_done),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .loader_cmd    (loader_cmd),
        .cmd_entry     (cmd_entry),
        .entry_state   (entry_state),
        .entry_loaded  (entry_loaded),
        .scan_position (scan_position)
    );

    always #5 clk = ~clk;

    // Move the scan pointer to the next entry, wrapping at the table end
    function automatic void advance_scan();
        tbl_scan = (tbl_scan + 1 >= NUM_ENTRIES) ? 0 : tbl_scan + 1;
    endfunction

    // Apply one request item to the predicted table and return its result item
    function automatic residency_result_t residency_step(logic [1:0] rq,
                                                         logic [ID_WIDTH-1:0] id,
                                                         logic done);
        residency_result_t r;
        int unsigned e;
        logic [2:0]  cmd;
        e = (rq == REQ_TICK) ? tbl_scan : int'(id);
        cmd = CMD_NONE;
        r.state = ST_UNLOADED;
        if (e < NUM_ENTRIES)
        begin
            case (rq)
                REQ_TICK:
                begin
                    case (tbl_state[e])
                        ST_UNLOADED:
                        begin
                            // Referenced entry starts loading; hold the pointer on it
                            if (tbl_refs[e] > 0)
                            begin
                                tbl_state[e] = ST_LOADING;
                                tbl_phase[e] = PH_IDLE;
                            end
                            else
                                advance_scan();
                        end
                        ST_LOADING:
                        begin
                            case (tbl_phase[e])
                                PH_IDLE:
                                begin
                                    cmd = CMD_SET_FILE;
                                    tbl_phase[e] = PH_READ;
                                end
                                PH_READ:
                                begin
                                    cmd = CMD_READ;
                                    tbl_phase[e] = PH_WAIT_READ;
                                end
                                PH_WAIT_READ:
                                    if (done)
                                        tbl_phase[e] = PH_DECODE;
                                PH_DECODE:
                                begin
                                    cmd = CMD_DECODE;
                                    tbl_phase[e] = PH_WAIT_DECODE;
                                end
                                PH_WAIT_DECODE:
                                    if (done)
                                        tbl_phase[e] = PH_END;
                                PH_END:
                                begin
                                    // Copy if still wanted, otherwise drop the result
                                    if (tbl_refs[e] > 0)
                                    begin
                                        cmd = CMD_COPY;
                                        tbl_state[e] = ST_LOADED;
                                    end
                                    else
                                        tbl_state[e] = ST_UNLOADED;
                                    tbl_phase[e] = PH_IDLE;
                                end
                                default:
                                    tbl_phase[e] = PH_IDLE;
                            endcase
                        end
                        ST_LOADED:
                        begin
                            if (tbl_refs[e] <= 0)
                                tbl_state[e] = ST_UNLOADING;
                            else
                                advance_scan();
                        end
                        default:
                        begin
                            // Unloading: a new reference brings the entry back
                            if (tbl_refs[e] > 0)
                                tbl_state[e] = ST_LOADED;
                            else
                            begin
                                cmd = CMD_FREE;
                                tbl_state[e] = ST_UNLOADED;
                            end
                        end
                    endcase
                end
                REQ_GET:
                    if (tbl_refs[e] < COUNT_MAX)
                        tbl_refs[e]++;
                REQ_RELEASE:
                    if (tbl_refs[e] > COUNT_MIN)
                        tbl_refs[e]--;
                default: ;
            endcase
            r.state = tbl_state[e];
        end
        r.cmd    = cmd;
        r.entry  = e[ID_WIDTH-1:0];
        r.loaded = (r.state == ST_LOADED);
        r.scan   = tbl_scan[ID_WIDTH-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatches < MAX_PRINTS)
            $display("%0t ns: %s got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Present one item and hold it until the block takes it. Valid is left
    // high so that the next item can follow on the very next edge.
    task automatic issue_request(logic [1:0] rq, logic [ID_WIDTH-1:0] id, logic done);
        in_valid    <= 1'b1;
        req_type    <= rq;
        res_id      <= id;
        loader_done <= done;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
    endtask

    // Drop valid to leave a gap in the input stream
    task automatic source_gap(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Walk entry 0 through a full load, an unload that is cancelled by a new
    // reference, and an unload that ends in a free; touch both id extremes.
    task automatic test_residency_cycle();
        issue_request(REQ_GET, 6'd0, 1'b0);
        issue_request(REQ_TICK, 6'd63, 1'b1);   // unloaded -> loading
        issue_request(REQ_TICK, 6'd0, 1'b0);    // set file
        issue_request(REQ_TICK, 6'd0, 1'b1);    // start read
        issue_request(REQ_TICK, 6'd0, 1'b0);    // wait for read done
        issue_request(REQ_TICK, 6'd0, 1'b1);    // read done
        issue_request(REQ_TICK, 6'd0, 1'b0);    // start decode
        source_gap(3);
        issue_request(REQ_TICK, 6'd0, 1'b0);    // wait for decode done
        issue_request(REQ_TICK, 6'd0, 1'b1);    // decode done
        issue_request(REQ_TICK, 6'd0, 1'b0);    // copy, now loaded
        issue_request(REQ_RELEASE, 6'd0, 1'b0);
        issue_request(REQ_TICK, 6'd0, 1'b0);    // loaded, no refs -> unloading
        issue_request(REQ_GET, 6'd0, 1'b1);
        issue_request(REQ_TICK, 6'd0, 1'b0);    // referenced again -> loaded
        issue_request(REQ_RELEASE, 6'd0, 1'b0);
        issue_request(REQ_TICK, 6'd0, 1'b0);    // -> unloading
        issue_request(REQ_TICK, 6'd0, 1'b0);    // free entry
        issue_request(REQ_TICK, 6'd0, 1'b0);    // idle unloaded -> pointer moves
        issue_request(REQ_GET, 6'd63, 1'b1);
        issue_request(REQ_RELEASE, 6'd63, 1'b0);
    endtask

    // Unused request code must change nothing and report res_id
    task automatic test_unused_request();
        issue_request(REQ_UNUSED, 6'd42, 1'b1);
        issue_request(REQ_UNUSED, 6'd21, 1'b0);
    endtask

    // Drive one count to both saturation bounds and back to zero
    task automatic test_count_limits();
        repeat (COUNT_MAX + 3) issue_request(REQ_GET, 6'd63, 1'b0);
        repeat (COUNT_MAX - COUNT_MIN + 3) issue_request(REQ_RELEASE, 6'd63, 1'b1);
        repeat (-COUNT_MIN) issue_request(REQ_GET, 6'd63, 1'b0);
    endtask

    // Mostly ticks and reference changes; half the ids lie near the scan pointer
    // so that entries load, drop, unload and free, the other half spread over the table.
    task automatic test_random_traffic(int n_items);
        int                  pick;
        logic [1:0]          rq;
        logic [ID_WIDTH-1:0] id;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 150 == 0)
                idling_on = (i < n_items - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                rq = REQ_TICK;
            else if (pick < 72)
                rq = REQ_GET;
            else if (pick < 96)
                rq = REQ_RELEASE;
            else
                rq = REQ_UNUSED;
            if ($urandom_range(0, 1) != 0)
                id = tbl_scan[ID_WIDTH-1:0] + ID_WIDTH'($urandom_range(0, 3));
            else
                id = ID_WIDTH'($urandom_range(0, NUM_ENTRIES - 1));
            if (idling_on && $urandom_range(0, 7) == 0)
                source_gap($urandom_range(1, 12));
            issue_request(rq, id, 1'($urandom_range(0, 1)));
        end
    endtask

    // Predict on every accepted input item, check every accepted output item.
    // Both are sampled at the edge, before this edge's drive takes effect.
    always @(posedge clk)
    begin : scoreboard
        residency_result_t want;
        if (in_valid && in_ready)
            pending_results.push_back(residency_step(req_type, res_id, loader_done));
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result item with nothing pending, cmd_entry", cmd_entry, -1);
            else
            begin
                want = pending_results.pop_front();
                if (loader_cmd !== want.cmd)
                    report_mismatch("loader_cmd", loader_cmd, want.cmd);
                if (cmd_entry !== want.entry)
                    report_mismatch("cmd_entry", cmd_entry, want.entry);
                if (entry_state !== want.state)
                    report_mismatch("entry_state", entry_state, want.state);
                if (entry_loaded !== want.loaded)
                    report_mismatch("entry_loaded", entry_loaded, want.loaded);
                if (scan_position !== want.scan)
                    report_mismatch("scan_position", scan_position, want.scan);
            end
        end
    end

    // Receiver pacing: random stall bursts, started only while idling is on
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            out_ready <= (sink_hold == 1);
        end
        else if (idling_on && $urandom_range(0, 9) == 0)
        begin
            sink_hold <= $urandom_range(1, 12);
            out_ready <= 1'b0;
        end
    end

    // Count cycles in which neither channel moves an item; end a hung run
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            tbl_state[i] = ST_UNLOADED;
            tbl_phase[i] = PH_IDLE;
            tbl_refs[i]  = 0;
        end
        tbl_scan = 0;

        // Hold reset, then release it; the table clear pass follows inside the block
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_residency_cycle();
        test_unused_request();
        test_count_limits();
        test_random_traffic(RANDOM_ITEMS);

        // Wait for every expected item, then watch for stray output items
        in_valid  <= 1'b0;
        idling_on = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/rrm_pkg.sv
hdl/rrm_entry_mem.sv
hdl/rrm_entry_update.sv
hdl/refcounted_residency_manager.sv
tb/testbench.sv
